>>> sv/drl_pkg.sv
// shared types, codes and helpers for the data run list decoder
package drl_pkg;

    localparam int unsigned WORD_W = 64;

    // decoder phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    localparam logic [3:0] FIELD_MAX = 4'd8;

    typedef logic [7:0]        t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [3:0]        t_count;

    typedef struct packed {
        t_byte data_byte;
        logic  list_start;
    } t_in_item;

    typedef struct packed {
        t_word      run_vcn;
        t_word      run_lcn;
        t_word      run_length;
        logic [1:0] status;
    } t_out_item;

    // sign extend a little-endian field of nbytes bytes; 0 or 8 and more pass through
    function automatic t_word sign_extend(input t_word v, input t_count nbytes);
        t_word r;
        unique case (nbytes)
            4'd1:    r = {{56{v[7]}},  v[7:0]};
            4'd2:    r = {{48{v[15]}}, v[15:0]};
            4'd3:    r = {{40{v[23]}}, v[23:0]};
            4'd4:    r = {{32{v[31]}}, v[31:0]};
            4'd5:    r = {{24{v[39]}}, v[39:0]};
            4'd6:    r = {{16{v[47]}}, v[47:0]};
            4'd7:    r = {{8{v[55]}},  v[55:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

>>> sv/drl_ifs.sv
// stream interfaces for the byte input and the run result output
interface drl_in_if;
    logic             valid;
    logic             ready;
    drl_pkg::t_byte   data_byte;
    logic             list_start;

    modport source (output valid, output data_byte, output list_start, input ready);
    modport sink   (input valid, input data_byte, input list_start, output ready);
endinterface

interface drl_out_if;
    logic             valid;
    logic             ready;
    drl_pkg::t_word   run_vcn;
    drl_pkg::t_word   run_lcn;
    drl_pkg::t_word   run_length;
    logic [1:0]       status;

    modport source (output valid, output run_vcn, output run_lcn, output run_length,
                    output status, input ready);
    modport sink   (input valid, input run_vcn, input run_lcn, input run_length,
                    input status, output ready);
endinterface

>>> sv/drl_in_stage.sv
// input register: holds one accepted byte until the decoder takes it
module drl_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    drl_in_if.sink            i_in,
    input  logic              i_adv,
    output logic              o_valid,
    output drl_pkg::t_in_item o_item
);
    import drl_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte  <= i_in.data_byte;
            r_item.list_start <= i_in.list_start;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> sv/drl_decode.sv
// run decoder: header parse, field shift-in, sign extension and cluster sums
module drl_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  drl_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output drl_pkg::t_out_item o_res
);
    import drl_pkg::*;

    logic [1:0] r_phase, n_phase;
    t_count     r_len_bytes, n_len_bytes;
    t_count     r_off_bytes, n_off_bytes;
    t_count     r_pos, n_pos;
    t_word      r_len_acc, n_len_acc;
    t_word      r_off_acc, n_off_acc;
    t_word      r_vcn, n_vcn;
    t_word      r_lcn, n_lcn;
    logic       r_oversize, n_oversize;

    logic [1:0] ph;
    t_word      base_vcn;
    t_word      base_lcn;
    t_word      shifted;
    logic [4:0] pos_inc;
    t_word      len_new;
    t_word      off_new;
    t_word      emit_len;
    t_word      emit_off;
    logic       emit;
    t_word      lcn_sum;

    assign ph       = i_item.list_start ? PH_HEADER : r_phase;
    assign base_vcn = i_item.list_start ? '0 : r_vcn;
    assign base_lcn = i_item.list_start ? '0 : r_lcn;

    // bytes past the eighth of a field are dropped
    assign shifted = r_pos[3] ? '0
                   : ({{(WORD_W-8){1'b0}}, i_item.data_byte} << {r_pos[2:0], 3'b000});
    assign pos_inc = {1'b0, r_pos} + 5'd1;
    assign len_new = r_len_acc | shifted;
    assign off_new = r_off_acc | shifted;

    assign emit_len = (ph == PH_LENGTH) ? len_new : r_len_acc;
    assign emit_off = (ph == PH_OFFSET) ? off_new : r_off_acc;
    assign lcn_sum  = base_lcn + sign_extend(emit_off, r_off_bytes);

    always_comb begin
        n_phase     = ph;
        n_len_bytes = r_len_bytes;
        n_off_bytes = r_off_bytes;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_off_acc   = r_off_acc;
        n_vcn       = base_vcn;
        n_lcn       = base_lcn;
        n_oversize  = r_oversize;
        emit        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (ph)
            PH_HEADER: begin
                if (i_item.data_byte == 8'd0) begin
                    o_res_valid = 1'b1;
                    o_res.status = ST_END;
                    n_phase = PH_IDLE;
                end else begin
                    n_len_bytes = i_item.data_byte[3:0];
                    n_off_bytes = i_item.data_byte[7:4];
                    n_pos       = '0;
                    n_len_acc   = '0;
                    n_off_acc   = '0;
                    n_oversize  = (i_item.data_byte[3:0] > FIELD_MAX)
                               || (i_item.data_byte[7:4] > FIELD_MAX);
                    n_phase     = (i_item.data_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                n_len_acc = len_new;
                n_pos     = pos_inc[3:0];
                if (pos_inc >= {1'b0, r_len_bytes}) begin
                    n_pos = '0;
                    if (r_off_bytes == 4'd0) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc = off_new;
                n_pos     = pos_inc[3:0];
                if (pos_inc >= {1'b0, r_off_bytes}) begin
                    n_pos = '0;
                    emit  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            o_res_valid      = 1'b1;
            o_res.run_vcn    = base_vcn;
            o_res.run_lcn    = lcn_sum;
            o_res.run_length = emit_len;
            o_res.status     = r_oversize ? ST_OVERSIZE : ST_RUN;
            n_vcn            = base_vcn + emit_len;
            n_lcn            = lcn_sum;
            n_phase          = PH_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_len_bytes <= '0;
            r_off_bytes <= '0;
            r_pos       <= '0;
            r_len_acc   <= '0;
            r_off_acc   <= '0;
            r_vcn       <= '0;
            r_lcn       <= '0;
            r_oversize  <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_len_bytes <= n_len_bytes;
            r_off_bytes <= n_off_bytes;
            r_pos       <= n_pos;
            r_len_acc   <= n_len_acc;
            r_off_acc   <= n_off_acc;
            r_vcn       <= n_vcn;
            r_lcn       <= n_lcn;
            r_oversize  <= n_oversize;
        end
    end
endmodule

>>> sv/drl_out_stage.sv
// result register: holds one run result until the sink takes it
module drl_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  drl_pkg::t_out_item i_res,
    output logic               o_free,
    drl_out_if.source          o_out
);
    import drl_pkg::*;

    logic      r_valid;
    t_out_item r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.run_vcn    = r_res.run_vcn;
    assign o_out.run_lcn    = r_res.run_lcn;
    assign o_out.run_length = r_res.run_length;
    assign o_out.status     = r_res.status;
endmodule

>>> sv/data_run_list_decoder.sv
// top level: extent list byte stream in, decoded runs out
// an accepted byte is decoded from the input register straight into the output register
// throughput: one byte per cycle; a byte moves on whenever the output register is free
// or being emptied, so a stalled sink holds the input register and then the input
// reset (synchronous, active low) empties both registers, clears running clusters
// and leaves the decoder waiting for a header byte
module data_run_list_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drl_in_if.sink    i_in,
    drl_out_if.source o_out
);
    import drl_pkg::*;

    logic      s1_valid;
    t_in_item  s1_item;
    logic      out_free;
    logic      adv;
    logic      res_valid;
    t_out_item res;

    assign adv = s1_valid && out_free;

    drl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    drl_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (s1_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    drl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // the decoder never advances into a full, stalled result register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !adv)
        else $error("decoder advanced while result register was stalled");

    // an end-of-list result carries zero cluster fields
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_END) |->
        (o_out.run_vcn == '0 && o_out.run_lcn == '0 && o_out.run_length == '0))
        else $error("end-of-list result with nonzero fields");

    // a stalled input byte is not lost when the sink stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !adv) |=> s1_valid && $stable(s1_item))
        else $error("pending input byte dropped or changed");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");
`endif
endmodule
